// ===== design/chebyshev_series_3d_evaluator_macros.svh =====
// assertion helpers shared by the checking code of the evaluator
`ifndef CHEBYSHEV_SERIES_3D_EVALUATOR_MACROS_SVH
`define CHEBYSHEV_SERIES_3D_EVALUATOR_MACROS_SVH

// same-cycle implication
`define CSE_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ===== design/cse_pkg.sv =====
package cse_pkg;

    localparam int CSE_DEG_X = 12;
    localparam int CSE_DEG_Y = 12;
    localparam int CSE_DEG_T = 6;

    // degree counters cover the largest allowed degree
    localparam int CSE_NW = 6;

    localparam logic signed [31:0] CSE_ONE_Q28 = 32'sh1000_0000;

    typedef enum logic [2:0] {
        CFG_X_OFFSET = 3'd0,
        CFG_X_INV    = 3'd1,
        CFG_Y_OFFSET = 3'd2,
        CFG_Y_INV    = 3'd3,
        CFG_T_OFFSET = 3'd4,
        CFG_T_INV    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_T = 2'd2
    } axis_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic        [10:0] coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_t;
    } in_t;

    typedef struct packed {
        logic signed [47:0] series_value;
        logic               overflowed;
    } out_t;

    typedef struct packed {
        logic signed [31:0] x_offset;
        logic signed [31:0] x_inv;
        logic signed [31:0] y_offset;
        logic signed [31:0] y_inv;
        logic signed [31:0] t_offset;
        logic signed [31:0] t_inv;
    } cfg_t;

    typedef struct packed {
        logic is_eval;
        logic idx_ok;
        in_t  item;
    } job_t;

    typedef struct packed {
        logic       valid;
        job_t       job;
        logic [1:0] count;
    } queue_sts_t;

    function automatic logic ovf32(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/cse_front.sv =====
module cse_front import cse_pkg::*; #(
    parameter int DEG_X = CSE_DEG_X,
    parameter int DEG_Y = CSE_DEG_Y,
    parameter int DEG_T = CSE_DEG_T
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_t        req,
    input  logic       take,
    output queue_sts_t sts
);
    localparam int DEPTH = (DEG_X + 1) * (DEG_Y + 1) * (DEG_T + 1);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       put;
    logic       get;
    job_t       job_in;

    assign full = (cnt_reg == 2'd2);
    assign put  = push && !full;
    assign get  = take && (cnt_reg != 2'd0);

    // tag each beat so the back end need not decode it again
    always_comb
    begin
        job_in.is_eval = (req.req_type == REQ_EVAL);
        job_in.idx_ok  = ({21'd0, req.coef_index} < 32'(DEPTH));
        job_in.item    = req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (put)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (get)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, put} - {1'b0, get};
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign sts.valid = (cnt_reg != 2'd0);
    assign sts.job   = slot_reg[rd_ptr_reg];
    assign sts.count = cnt_reg;

endmodule

// ===== design/cse_back.sv =====
module cse_back import cse_pkg::*; #(
    parameter int DEG_X = CSE_DEG_X,
    parameter int DEG_Y = CSE_DEG_Y,
    parameter int DEG_T = CSE_DEG_T
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  queue_sts_t sts,
    output logic       take,
    input  logic       pop,
    output logic       empty,
    output out_t       rsp
);
    localparam int DEPTH = (DEG_X + 1) * (DEG_Y + 1) * (DEG_T + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(DEG_X + 1);
    localparam int YW    = $clog2(DEG_Y + 1);
    localparam int TW    = $clog2(DEG_T + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MAP0, S_MAP1, S_REC0, S_REC1, S_MAC, S_DRAIN, S_DONE
    } state_t;

    state_t state_reg;
    axis_t  axis_reg;
    job_t   job_reg;

    logic signed [31:0] coef_mem [DEPTH];
    logic signed [31:0] tx_mem [DEG_X + 1];
    logic signed [31:0] ty_mem [DEG_Y + 1];
    logic signed [31:0] tt_mem [DEG_T + 1];

    logic [CSE_NW-1:0]  n_reg;
    logic signed [64:0] map_prod_reg;
    logic signed [63:0] rec_prod_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] prev_reg;

    logic [CSE_NW-1:0] ci_reg;
    logic [CSE_NW-1:0] cj_reg;
    logic [CSE_NW-1:0] ck_reg;
    logic [AW-1:0]     caddr_reg;

    // term pipeline
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0] c1_reg, tx1_reg, ty1_reg, tt1_reg;
    logic [1:0]         h1_reg, h2_reg, h3_reg, h4_reg;
    logic signed [63:0] prod1_reg, prod2_reg, prod3_reg;
    logic signed [31:0] ty2_reg, tt2_reg, tt3_reg;
    logic               f3_reg, f4_reg;

    logic signed [47:0] acc_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    logic signed [31:0] pos_sel;
    logic signed [31:0] off_sel;
    logic signed [31:0] inv_sel;
    logic [CSE_NW-1:0]  deg_sel;
    logic signed [32:0] diff;
    logic signed [65:0] map_r;
    logic signed [65:0] rec_r;
    logic               tw_en;
    logic [CSE_NW-1:0]  tw_addr;
    logic signed [31:0] tw_data;
    logic signed [65:0] p_r;
    logic signed [65:0] q_r;
    logic signed [31:0] p_s;
    logic signed [31:0] q_s;
    logic [4:0]         sh;
    logic signed [65:0] term;
    logic signed [65:0] sum;
    logic               sum_hi;
    logic               sum_lo;
    logic [1:0]         h_now;
    logic               out_free;
    logic               ovf_set;

    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                pos_sel = job_reg.item.pos_x;
                off_sel = cfg.x_offset;
                inv_sel = cfg.x_inv;
                deg_sel = CSE_NW'(DEG_X);
            end
            AXIS_Y:
            begin
                pos_sel = job_reg.item.pos_y;
                off_sel = cfg.y_offset;
                inv_sel = cfg.y_inv;
                deg_sel = CSE_NW'(DEG_Y);
            end
            default:
            begin
                pos_sel = job_reg.item.pos_t;
                off_sel = cfg.t_offset;
                inv_sel = cfg.t_inv;
                deg_sel = CSE_NW'(DEG_T);
            end
        endcase
    end

    assign diff  = 33'(pos_sel) - 33'(off_sel);
    assign map_r = (66'(map_prod_reg) + 66'sd134217728) >>> 28;
    assign rec_r = ((66'(rec_prod_reg) + 66'sd67108864) >>> 27) - 66'(prev_reg);

    // polynomial table write port
    always_comb
    begin
        tw_en   = 1'b0;
        tw_addr = n_reg;
        tw_data = cur_reg;
        case (state_reg)
            S_MAP1:
            begin
                tw_en   = 1'b1;
                tw_addr = '0;
                tw_data = CSE_ONE_Q28;
            end
            S_REC0:
            begin
                tw_en = (n_reg == CSE_NW'(1));
            end
            S_REC1:
            begin
                tw_en   = 1'b1;
                tw_addr = n_reg + CSE_NW'(1);
                tw_data = sat32(rec_r);
            end
            default:
            begin
                tw_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        p_r    = (66'(prod1_reg) + 66'sd134217728) >>> 28;
        q_r    = (66'(prod2_reg) + 66'sd134217728) >>> 28;
        p_s    = sat32(p_r);
        q_s    = sat32(q_r);
        sh     = 5'd28 + {3'd0, h4_reg};
        term   = (66'(prod3_reg) + (66'sd1 <<< (sh - 5'd1))) >>> sh;
        sum    = 66'(acc_reg) + term;
        sum_hi = sum > 66'sd140737488355327;
        sum_lo = sum < -66'sd140737488355328;
        h_now  = {1'b0, ci_reg == '0} + {1'b0, cj_reg == '0} + {1'b0, ck_reg == '0};
    end

    assign ovf_set = (v3_reg && ovf32(q_r))
                  || (v4_reg && (f4_reg || sum_hi || sum_lo))
                  || ((state_reg == S_MAP1) && ovf32(map_r))
                  || ((state_reg == S_REC1) && ovf32(rec_r));

    assign take     = (state_reg == S_IDLE) && sts.valid;
    assign out_free = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_X;
            n_reg         <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            caddr_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && sts.valid && sts.job.is_eval)
            begin
                ovf_reg <= 1'b0;
            end
            else if (ovf_set)
            begin
                ovf_reg <= 1'b1;
            end
            v1_reg <= 1'b0;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (sts.valid && sts.job.is_eval)
                    begin
                        axis_reg  <= AXIS_X;
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        ck_reg    <= '0;
                        caddr_reg <= '0;
                        state_reg <= S_MAP0;
                    end
                end
                S_MAP0:
                begin
                    state_reg <= S_MAP1;
                end
                S_MAP1:
                begin
                    n_reg     <= CSE_NW'(1);
                    state_reg <= S_REC0;
                end
                S_REC0:
                begin
                    state_reg <= S_REC1;
                end
                S_REC1:
                begin
                    if (n_reg == deg_sel - CSE_NW'(1))
                    begin
                        case (axis_reg)
                            AXIS_X:
                            begin
                                axis_reg  <= AXIS_Y;
                                state_reg <= S_MAP0;
                            end
                            AXIS_Y:
                            begin
                                axis_reg  <= AXIS_T;
                                state_reg <= S_MAP0;
                            end
                            default:
                            begin
                                state_reg <= S_MAC;
                            end
                        endcase
                    end
                    else
                    begin
                        n_reg     <= n_reg + CSE_NW'(1);
                        state_reg <= S_REC0;
                    end
                end
                S_MAC:
                begin
                    v1_reg    <= 1'b1;
                    caddr_reg <= caddr_reg + AW'(1);
                    if (ci_reg == CSE_NW'(DEG_X))
                    begin
                        ci_reg <= '0;
                        if (cj_reg == CSE_NW'(DEG_Y))
                        begin
                            cj_reg <= '0;
                            ck_reg <= ck_reg + CSE_NW'(1);
                            if (ck_reg == CSE_NW'(DEG_T))
                            begin
                                state_reg <= S_DRAIN;
                            end
                        end
                        else
                        begin
                            cj_reg <= cj_reg + CSE_NW'(1);
                        end
                    end
                    else
                    begin
                        ci_reg <= ci_reg + CSE_NW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= sts.job;
        end
        if (state_reg == S_IDLE && sts.valid && sts.job.is_eval)
        begin
            acc_reg <= '0;
        end
        if (state_reg == S_MAP0)
        begin
            map_prod_reg <= diff * inv_sel;
        end
        if (state_reg == S_MAP1)
        begin
            u_reg    <= sat32(map_r);
            cur_reg  <= sat32(map_r);
            prev_reg <= CSE_ONE_Q28;
        end
        if (state_reg == S_REC0)
        begin
            rec_prod_reg <= u_reg * cur_reg;
        end
        if (state_reg == S_REC1)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= sat32(rec_r);
        end
        c1_reg  <= coef_mem[caddr_reg];
        tx1_reg <= tx_mem[XW'(ci_reg)];
        ty1_reg <= ty_mem[YW'(cj_reg)];
        tt1_reg <= tt_mem[TW'(ck_reg)];
        h1_reg  <= h_now;
        prod1_reg <= c1_reg * tx1_reg;
        ty2_reg   <= ty1_reg;
        tt2_reg   <= tt1_reg;
        h2_reg    <= h1_reg;
        prod2_reg <= p_s * ty2_reg;
        f3_reg    <= ovf32(p_r);
        tt3_reg   <= tt2_reg;
        h3_reg    <= h2_reg;
        prod3_reg <= q_s * tt3_reg;
        f4_reg    <= f3_reg;
        h4_reg    <= h3_reg;
        if (v4_reg)
        begin
            if (sum_hi)
            begin
                acc_reg <= 48'sh7fff_ffff_ffff;
            end
            else if (sum_lo)
            begin
                acc_reg <= 48'sh8000_0000_0000;
            end
            else
            begin
                acc_reg <= sum[47:0];
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_reg.series_value <= acc_reg;
            out_reg.overflowed   <= ovf_reg;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (take && !sts.job.is_eval && sts.job.idx_ok)
        begin
            coef_mem[AW'(sts.job.item.coef_index)] <= sts.job.item.coef_value;
        end
        if (tw_en && axis_reg == AXIS_X)
        begin
            tx_mem[XW'(tw_addr)] <= tw_data;
        end
        if (tw_en && axis_reg == AXIS_Y)
        begin
            ty_mem[YW'(tw_addr)] <= tw_data;
        end
        if (tw_en && axis_reg == AXIS_T)
        begin
            tt_mem[TW'(tw_addr)] <= tw_data;
        end
    end

    assign empty = !out_valid_reg;
    assign rsp   = out_reg;

endmodule

// ===== design/chebyshev_series_3d_evaluator.sv =====
// channel   handshake          payload
// request   push / full        req (in_t)
// result    empty / pop        rsp (out_t)
// config    cfg_we             cfg_index, cfg_data
//
// a load is written to the coefficient store as the back end takes it; an evaluation
// maps and expands all three axes, then sums every term of the series,
// paced by one term per cycle on the coefficient read port
// a two-entry queue holds requests while the back end works
// a finished result waits in the output register while the next request runs
// reset restores the config registers; the coefficient store is not cleared
`include "chebyshev_series_3d_evaluator_macros.svh"

module chebyshev_series_3d_evaluator import cse_pkg::*; #(
    parameter int DEG_X = CSE_DEG_X,
    parameter int DEG_Y = CSE_DEG_Y,
    parameter int DEG_T = CSE_DEG_T
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_t         req,
    output logic        empty,
    input  logic        pop,
    output out_t        rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    cfg_t       cfg_reg;
    queue_sts_t sts;
    logic       take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset <= 32'sd843314857;
            cfg_reg.x_inv    <= 32'sd85445659;
            cfg_reg.y_offset <= 32'sd843314857;
            cfg_reg.y_inv    <= 32'sd85445659;
            cfg_reg.t_offset <= 32'sd134217728;
            cfg_reg.t_inv    <= 32'sd536870912;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_OFFSET: cfg_reg.x_offset <= cfg_data;
                CFG_X_INV:    cfg_reg.x_inv    <= cfg_data;
                CFG_Y_OFFSET: cfg_reg.y_offset <= cfg_data;
                CFG_Y_INV:    cfg_reg.y_inv    <= cfg_data;
                CFG_T_OFFSET: cfg_reg.t_offset <= cfg_data;
                CFG_T_INV:    cfg_reg.t_inv    <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    cse_front #(
        .DEG_X(DEG_X),
        .DEG_Y(DEG_Y),
        .DEG_T(DEG_T)
    ) u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .full (full),
        .req  (req),
        .take (take),
        .sts  (sts)
    );

    cse_back #(
        .DEG_X(DEG_X),
        .DEG_Y(DEG_Y),
        .DEG_T(DEG_T)
    ) u_back (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_reg),
        .sts  (sts),
        .take (take),
        .pop  (pop),
        .empty(empty),
        .rsp  (rsp)
    );

    `CSE_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !full && !take, sts.count != 2'd0)
    `CSE_ASSERT_NOW(a_take_has_beat, clk, rst_n, take, sts.count != 2'd0)

endmodule
